FILE: rtl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types, register codes and tables for the axis rotation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rpa_pkg;

    typedef enum logic [2:0] {
        SU_IDLE,
        SU_NORM,
        SU_SQR,
        SU_SQRT,
        SU_DIV,
        SU_CORDIC,
        SU_FIN
    } rpa_su_state_t;

    localparam logic [2:0] REG_PIVOT_X = 3'd0;
    localparam logic [2:0] REG_PIVOT_Y = 3'd1;
    localparam logic [2:0] REG_PIVOT_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X   = 3'd3;
    localparam logic [2:0] REG_DIR_Y   = 3'd4;
    localparam logic [2:0] REG_DIR_Z   = 3'd5;
    localparam logic [2:0] REG_TURN    = 3'd6;

    localparam logic signed [31:0] Q_ONE           = 32'sh4000_0000;
    localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sh0_26DD_3B6A;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 61;

    // Per-run coefficients: unit axis and cos/sin in Q2.30, omc = 1 - cos
    typedef struct packed {
        logic signed [31:0] kx;
        logic signed [31:0] ky;
        logic signed [31:0] kz;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
        logic signed [32:0] omc;
        logic               zero;
    } rpa_coef_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0029;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0003;
            5'd29:   v = 32'h0000_0001;
            5'd30:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rpa_mulq.sv
// ----------------------------------------------------------------------------
// rpa_mulq
// Registered sign-magnitude multiply by a Q2.30 factor, truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_mulq #(
    parameter int AW = 33
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [32:0]   f,
    output logic signed [AW:0]   q_reg
);

    logic [AW-1:0] ma;
    logic [32:0]   mf;
    logic [AW+32:0] prod;
    logic [AW:0]   mag_q;
    logic          neg;

    always_comb begin
        ma    = a[AW-1] ? AW'(~a + 1'b1) : AW'(a);
        mf    = f[32] ? 33'(~f + 1'b1) : 33'(f);
        prod  = (AW+33)'(ma) * (AW+33)'(mf);
        mag_q = prod[AW+30:30];
        neg   = a[AW-1] ^ f[32];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= neg ? -$signed(mag_q) : $signed(mag_q);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rpa_setup.sv
// ----------------------------------------------------------------------------
// rpa_setup
// Run setup sequencer: normalizes the axis (square root, divide) and derives
// cos/sin by CORDIC, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_setup #(
    parameter int CW           = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [CW-1:0] dir_x,
    input  logic signed [CW-1:0] dir_y,
    input  logic signed [CW-1:0] dir_z,
    input  logic [15:0]          turn_angle,
    output logic                 busy,
    output logic                 fin,
    output rpa_pkg::rpa_coef_t   coef_reg
);
    import rpa_pkg::*;

    localparam int MW = (CW > 30) ? CW : 31;

    rpa_su_state_t state_reg, state_next;

    logic signed [CW-1:0] dir_in [3];
    logic [MW-1:0] mag_in [3];
    logic [MW-1:0] big_in;
    logic          zero_in;
    logic [31:0]   t_in, tf_in;
    logic          flip_in;

    logic [MW-1:0] m_reg [3];
    logic          neg_reg [3];
    logic [MW-1:0] big_reg;
    logic          zero_reg, flip_reg;
    logic [5:0]    cnt_reg;
    logic [1:0]    comp_reg;
    logic [63:0]   n_reg, res_reg, bit_reg;
    logic [30:0]   len_reg, rem_reg;
    logic [60:0]   num_reg;
    logic [31:0]   q_reg;
    logic signed [31:0] u_reg [3];
    logic signed [33:0] x_reg, y_reg, z_reg;

    logic [59:0] sq;
    logic [63:0] rb, n_nxt, res_nxt;
    logic        sq_ge;
    logic [31:0] rem2, q_nxt, u_val;
    logic        dv_ge;
    logic [30:0] rem_nxt;
    logic [4:0]  cs;
    logic signed [33:0] xs, ys, at;
    logic signed [33:0] cx, cy;
    logic signed [31:0] cos_f, sin_f;

    assign dir_in[0] = dir_x;
    assign dir_in[1] = dir_y;
    assign dir_in[2] = dir_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_in[i] = dir_in[i][CW-1] ? MW'(CW'(~dir_in[i] + 1'b1)) : MW'(CW'(dir_in[i]));
        end
        big_in = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
        big_in = (big_in > mag_in[2]) ? big_in : mag_in[2];
        zero_in = (big_in == '0);
        t_in    = {turn_angle, 16'h0000};
        // second and third quarter: fold by half a turn, negate afterwards
        flip_in = t_in[31] ^ t_in[30];
        tf_in   = flip_in ? (t_in - 32'h8000_0000) : t_in;
    end

    // sum of squares, square root and divide steps
    always_comb begin
        sq      = m_reg[comp_reg][29:0] * m_reg[comp_reg][29:0];
        rb      = res_reg + bit_reg;
        sq_ge   = (n_reg >= rb);
        n_nxt   = sq_ge ? (n_reg - rb) : n_reg;
        res_nxt = sq_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
        rem2    = {rem_reg, num_reg[60]};
        dv_ge   = (rem2 >= {1'b0, len_reg});
        rem_nxt = dv_ge ? 31'(rem2 - {1'b0, len_reg}) : rem2[30:0];
        q_nxt   = {q_reg[30:0], dv_ge};
        u_val   = (q_nxt > 32'(Q_ONE)) ? 32'(Q_ONE) : q_nxt;
    end

    // CORDIC step and final clamp
    always_comb begin
        cs = cnt_reg[4:0];
        xs = x_reg >>> cs;
        ys = y_reg >>> cs;
        at = $signed({2'b00, atan_lut(cs)});
        if (x_reg > 34'(Q_ONE)) begin
            cx = 34'(Q_ONE);
        end else if (x_reg < -34'(Q_ONE)) begin
            cx = -34'(Q_ONE);
        end else begin
            cx = x_reg;
        end
        if (y_reg > 34'(Q_ONE)) begin
            cy = 34'(Q_ONE);
        end else if (y_reg < -34'(Q_ONE)) begin
            cy = -34'(Q_ONE);
        end else begin
            cy = y_reg;
        end
        cos_f = flip_reg ? 32'(-cx) : 32'(cx);
        sin_f = flip_reg ? 32'(-cy) : 32'(cy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        fin        = 1'b0;
        busy       = (state_reg != SU_IDLE);
        unique case (state_reg)
            SU_IDLE: begin
                if (start) begin
                    state_next = zero_in ? SU_CORDIC : SU_NORM;
                end
            end
            SU_NORM: begin
                if (big_reg[MW-1:30] == '0 && big_reg[29]) begin
                    state_next = SU_SQR;
                end
            end
            SU_SQR: begin
                if (comp_reg == 2'd2) begin
                    state_next = SU_SQRT;
                end
            end
            SU_SQRT: begin
                if (cnt_reg == 6'(SQRT_STEPS - 1)) begin
                    state_next = SU_DIV;
                end
            end
            SU_DIV: begin
                if (cnt_reg == 6'(DIV_STEPS) && comp_reg == 2'd2) begin
                    state_next = SU_CORDIC;
                end
            end
            SU_CORDIC: begin
                if (cnt_reg == 6'(CORDIC_STEPS - 1)) begin
                    state_next = SU_FIN;
                end
            end
            SU_FIN: begin
                fin        = 1'b1;
                state_next = SU_IDLE;
            end
            default: state_next = SU_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            comp_reg <= '0;
            coef_reg <= '0;
        end else begin
            case (state_reg)
                SU_IDLE: begin
                    if (start) begin
                        for (int i = 0; i < 3; i++) begin
                            m_reg[i]   <= mag_in[i];
                            neg_reg[i] <= dir_in[i][CW-1];
                            u_reg[i]   <= '0;
                        end
                        big_reg  <= big_in;
                        zero_reg <= zero_in;
                        flip_reg <= flip_in;
                        z_reg    <= 34'($signed(tf_in));
                        x_reg    <= CORDIC_INV_GAIN;
                        y_reg    <= '0;
                        cnt_reg  <= '0;
                        comp_reg <= '0;
                    end
                end
                SU_NORM: begin
                    // bring the largest magnitude into [2^29, 2^30)
                    if (big_reg[MW-1:30] != '0) begin
                        big_reg <= big_reg >> 1;
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                    end else if (!big_reg[29]) begin
                        big_reg <= big_reg << 1;
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] << 1;
                    end else begin
                        n_reg    <= '0;
                        comp_reg <= '0;
                    end
                end
                SU_SQR: begin
                    n_reg    <= n_reg + 64'(sq);
                    comp_reg <= comp_reg + 2'd1;
                    if (comp_reg == 2'd2) begin
                        res_reg <= '0;
                        bit_reg <= 64'h4000_0000_0000_0000;
                        cnt_reg <= '0;
                    end
                end
                SU_SQRT: begin
                    n_reg   <= n_nxt;
                    res_reg <= res_nxt;
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(SQRT_STEPS - 1)) begin
                        len_reg  <= res_nxt[30:0];
                        cnt_reg  <= '0;
                        comp_reg <= '0;
                    end
                end
                SU_DIV: begin
                    if (cnt_reg == '0) begin
                        // load numerator m*2^30 + len/2
                        num_reg <= {m_reg[comp_reg][30:0], 30'h0}
                                   + 61'(len_reg >> 1);
                        rem_reg <= '0;
                        q_reg   <= '0;
                        cnt_reg <= 6'd1;
                    end else begin
                        num_reg <= num_reg << 1;
                        rem_reg <= rem_nxt;
                        q_reg   <= q_nxt;
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'(DIV_STEPS)) begin
                            u_reg[comp_reg] <= neg_reg[comp_reg] ? -$signed(u_val)
                                                                 : $signed(u_val);
                            comp_reg <= comp_reg + 2'd1;
                            cnt_reg  <= '0;
                        end
                    end
                end
                SU_CORDIC: begin
                    if (!z_reg[33]) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                SU_FIN: begin
                    coef_reg.kx    <= u_reg[0];
                    coef_reg.ky    <= u_reg[1];
                    coef_reg.kz    <= u_reg[2];
                    coef_reg.cos_v <= cos_f;
                    coef_reg.sin_v <= sin_f;
                    coef_reg.omc   <= 33'sh0_4000_0000 - {cos_f[31], cos_f};
                    coef_reg.zero  <= zero_reg;
                    cnt_reg        <= '0;
                end
                default: begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rpa_datapath.sv
// ----------------------------------------------------------------------------
// rpa_datapath
// Six-stage point pipeline: offset, axis products, dot and cross, sin and
// projection products, (1-cos) product, sum and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_datapath #(
    parameter int CW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_ok,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [CW-1:0] s_x,
    input  logic signed [CW-1:0] s_y,
    input  logic signed [CW-1:0] s_z,
    input  logic                 s_last,
    input  logic signed [CW-1:0] piv_x,
    input  logic signed [CW-1:0] piv_y,
    input  logic signed [CW-1:0] piv_z,
    input  rpa_pkg::rpa_coef_t   coef,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [CW-1:0] m_x,
    output logic signed [CW-1:0] m_y,
    output logic signed [CW-1:0] m_z,
    output logic                 m_last,
    output logic                 pipe_empty
);
    import rpa_pkg::*;

    logic [5:0] v_reg, en;
    logic       s_fire;

    logic signed [CW-1:0] p_in [3];
    logic signed [CW-1:0] a_in [3];
    logic signed [32:0]   k33 [3];
    logic signed [32:0]   c33, s33;

    logic signed [CW:0]   d1_reg [3];
    logic signed [CW-1:0] a1_reg [3], a2_reg [3], a3_reg [3], a4_reg [3], a5_reg [3];
    logic                 l1_reg, l2_reg, l3_reg, l4_reg, l5_reg, l6_reg;
    logic signed [CW+1:0] kd2 [3][3];
    logic signed [CW+1:0] dc2 [3];
    logic signed [CW+1:0] dc3_reg [3], dc4_reg [3], dc5_reg [3];
    logic signed [CW+3:0] dot3_reg;
    logic signed [CW+2:0] cr3_reg [3];
    logic signed [CW+3:0] crs4 [3];
    logic signed [CW+3:0] crs5_reg [3];
    logic signed [CW+4:0] kdot4 [3];
    logic signed [CW+5:0] kdo5 [3];
    logic signed [CW+7:0] sum [3];
    logic signed [CW-1:0] r_sat [3];
    logic signed [CW-1:0] r6_reg [3];

    assign p_in[0] = s_x;
    assign p_in[1] = s_y;
    assign p_in[2] = s_z;
    assign a_in[0] = piv_x;
    assign a_in[1] = piv_y;
    assign a_in[2] = piv_z;
    assign k33[0]  = {coef.kx[31], coef.kx};
    assign k33[1]  = {coef.ky[31], coef.ky};
    assign k33[2]  = {coef.kz[31], coef.kz};
    assign c33     = {coef.cos_v[31], coef.cos_v};
    assign s33     = {coef.sin_v[31], coef.sin_v};

    // each stage advances when empty or when the next one moves
    always_comb begin
        en[5] = !v_reg[5] || m_ready;
        for (int k = 4; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_ready    = en[0] && in_ok;
    assign s_fire     = s_valid && s_ready;
    assign pipe_empty = (v_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= s_fire;
            for (int k = 1; k < 6; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage 1: offset from pivot; a zero axis forwards the point as the pivot
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i] <= coef.zero ? '0 : ((CW+1)'(p_in[i]) - (CW+1)'(a_in[i]));
                a1_reg[i] <= coef.zero ? p_in[i] : a_in[i];
            end
            l1_reg <= s_last;
        end
    end

    // stage 2: k_i * d_j and d_i * cos
    for (genvar i = 0; i < 3; i++) begin : g_s2
        for (genvar j = 0; j < 3; j++) begin : g_kd
            rpa_mulq #(.AW(CW + 1)) u_kd (
                .aclk  (aclk),
                .en    (en[1]),
                .a     (d1_reg[j]),
                .f     (k33[i]),
                .q_reg (kd2[i][j])
            );
        end
        rpa_mulq #(.AW(CW + 1)) u_dc (
            .aclk  (aclk),
            .en    (en[1]),
            .a     (d1_reg[i]),
            .f     (c33),
            .q_reg (dc2[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) a2_reg[i] <= a1_reg[i];
            l2_reg <= l1_reg;
        end
    end

    // stage 3: dot and cross products
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            dot3_reg   <= (CW+4)'(kd2[0][0]) + (CW+4)'(kd2[1][1]) + (CW+4)'(kd2[2][2]);
            cr3_reg[0] <= (CW+3)'(kd2[1][2]) - (CW+3)'(kd2[2][1]);
            cr3_reg[1] <= (CW+3)'(kd2[2][0]) - (CW+3)'(kd2[0][2]);
            cr3_reg[2] <= (CW+3)'(kd2[0][1]) - (CW+3)'(kd2[1][0]);
            for (int i = 0; i < 3; i++) begin
                a3_reg[i]  <= a2_reg[i];
                dc3_reg[i] <= dc2[i];
            end
            l3_reg <= l2_reg;
        end
    end

    // stage 4: cross * sin and k * dot
    for (genvar i = 0; i < 3; i++) begin : g_s4
        rpa_mulq #(.AW(CW + 3)) u_crs (
            .aclk  (aclk),
            .en    (en[3]),
            .a     (cr3_reg[i]),
            .f     (s33),
            .q_reg (crs4[i])
        );
        rpa_mulq #(.AW(CW + 4)) u_kdot (
            .aclk  (aclk),
            .en    (en[3]),
            .a     (dot3_reg),
            .f     (k33[i]),
            .q_reg (kdot4[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                a4_reg[i]  <= a3_reg[i];
                dc4_reg[i] <= dc3_reg[i];
            end
            l4_reg <= l3_reg;
        end
    end

    // stage 5: projection * (1 - cos)
    for (genvar i = 0; i < 3; i++) begin : g_s5
        rpa_mulq #(.AW(CW + 5)) u_kdo (
            .aclk  (aclk),
            .en    (en[4]),
            .a     (kdot4[i]),
            .f     (coef.omc),
            .q_reg (kdo5[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                a5_reg[i]   <= a4_reg[i];
                dc5_reg[i]  <= dc4_reg[i];
                crs5_reg[i] <= crs4[i];
            end
            l5_reg <= l4_reg;
        end
    end

    // stage 6: sum and saturate to the coordinate range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = (CW+8)'(a5_reg[i]) + (CW+8)'(dc5_reg[i]) + (CW+8)'(crs5_reg[i])
                     + (CW+8)'(kdo5[i]);
            if ((&sum[i][CW+7:CW-1]) || !(|sum[i][CW+7:CW-1])) begin
                r_sat[i] = sum[i][CW-1:0];
            end else if (sum[i][CW+7]) begin
                r_sat[i] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                r_sat[i] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int i = 0; i < 3; i++) r6_reg[i] <= r_sat[i];
            l6_reg <= l5_reg;
        end
    end

    assign m_valid = v_reg[5];
    assign m_x     = r6_reg[0];
    assign m_y     = r6_reg[1];
    assign m_z     = r6_reg[2];
    assign m_last  = l6_reg;

endmodule

`default_nettype wire

FILE: rtl/rotate_points_about_axis_unit.sv
// ----------------------------------------------------------------------------
// rotate_points_about_axis_unit
// Rotates streamed 3D points about a configured axis by a configured angle.
// ----------------------------------------------------------------------------
// An accepted point passes six registered stages to its rotated result.
// Throughput: one point per cycle inside a run while m_tready does not stall it.
// First point of a run: waits for the pipeline to drain, then the setup
//   sequencer normalizes the axis, sums the squares, takes the square root,
//   divides each component and runs CORDIC (zero axis skips to CORDIC).
// Reset: synchronous, active low; registers return to their reset values.
`default_nettype none

module rotate_points_about_axis_unit #(
    parameter int COORD_WIDTH  = 32,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    // fields from bit 0: point_x, point_y, point_z, zero fill to whole bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic                               s_tlast,
    // fields from bit 0: rot_x, rot_y, rot_z, zero fill to whole bytes
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic                               m_tlast,
    // fields from bit 0: axis_zero
    output logic [0:0]                         m_tuser,
    input  logic                                            psel,
    input  logic                                            penable,
    input  logic                                            pwrite,
    input  logic [((COORD_WIDTH > 32) ? 3 : 2)+2:0]         paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]       pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]       prdata,
    output logic                                            pready
);
    import rpa_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int TDW = ((3 * CW + 7) / 8) * 8;
    localparam int PDW = (CW > 32) ? 64 : 32;
    localparam int ASH = (CW > 32) ? 3 : 2;

    logic [CW-1:0] pivx_reg, pivy_reg, pivz_reg, dirx_reg, diry_reg, dirz_reg;
    logic [15:0]   turn_reg;
    logic          setup_done_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    logic       su_busy, su_fin, su_start, dp_empty;
    rpa_coef_t  coef;
    logic signed [CW-1:0] mx, my, mz;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ASH+2:ASH];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pivx_reg <= '0;
            pivy_reg <= '0;
            pivz_reg <= '0;
            dirx_reg <= '0;
            diry_reg <= '0;
            dirz_reg <= CW'(1) << FRAC_BITS;
            turn_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PIVOT_X: pivx_reg <= pwdata[CW-1:0];
                REG_PIVOT_Y: pivy_reg <= pwdata[CW-1:0];
                REG_PIVOT_Z: pivz_reg <= pwdata[CW-1:0];
                REG_DIR_X:   dirx_reg <= pwdata[CW-1:0];
                REG_DIR_Y:   diry_reg <= pwdata[CW-1:0];
                REG_DIR_Z:   dirz_reg <= pwdata[CW-1:0];
                REG_TURN:    turn_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PIVOT_X: prdata = PDW'(pivx_reg);
            REG_PIVOT_Y: prdata = PDW'(pivy_reg);
            REG_PIVOT_Z: prdata = PDW'(pivz_reg);
            REG_DIR_X:   prdata = PDW'(dirx_reg);
            REG_DIR_Y:   prdata = PDW'(diry_reg);
            REG_DIR_Z:   prdata = PDW'(dirz_reg);
            REG_TURN:    prdata = PDW'(turn_reg);
            default:     prdata = '0;
        endcase
    end

    // latch a fresh setup only once earlier items have left the pipeline
    assign su_start = s_tvalid && !setup_done_reg && !su_busy && dp_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_done_reg <= 1'b0;
        end else if (su_fin) begin
            setup_done_reg <= 1'b1;
        end else if (s_tvalid && s_tready && s_tlast) begin
            setup_done_reg <= 1'b0;
        end
    end

    rpa_setup #(
        .CW           (CW),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_setup (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (su_start),
        .dir_x      ($signed(dirx_reg)),
        .dir_y      ($signed(diry_reg)),
        .dir_z      ($signed(dirz_reg)),
        .turn_angle (turn_reg),
        .busy       (su_busy),
        .fin        (su_fin),
        .coef_reg   (coef)
    );

    rpa_datapath #(
        .CW (CW)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_ok      (setup_done_reg),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_x        ($signed(s_tdata[CW-1:0])),
        .s_y        ($signed(s_tdata[2*CW-1:CW])),
        .s_z        ($signed(s_tdata[3*CW-1:2*CW])),
        .s_last     (s_tlast),
        .piv_x      ($signed(pivx_reg)),
        .piv_y      ($signed(pivy_reg)),
        .piv_z      ($signed(pivz_reg)),
        .coef       (coef),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_x        (mx),
        .m_y        (my),
        .m_z        (mz),
        .m_last     (m_tlast),
        .pipe_empty (dp_empty)
    );

    assign m_tdata    = TDW'({mz, my, mx});
    assign m_tuser[0] = coef.zero;

    a_no_accept_in_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        su_busy |-> !s_tready)
        else $error("item accepted while run setup is in progress");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !setup_done_reg)
        else $error("run setup still marked done after last item");

    a_zero_axis_coef: assert property (@(posedge aclk) disable iff (!aresetn)
        coef.zero |-> (coef.kx == '0 && coef.ky == '0 && coef.kz == '0))
        else $error("zero axis with nonzero unit axis");

endmodule

`default_nettype wire
